[rtl/core/assert_macros.svh]
// assertion macros used by the core top level rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/core/vgrt_pkg.sv]
// shared types and constants for the voxel grid ray traversal core
// no dependencies
package vgrt_pkg;
    localparam int GRID_BITS_DEF = 4;
    localparam logic [15:0] MAX_DIST_RST = 16'd16384;
    localparam logic [15:0] DELTA_MAX = 16'hFFFF;
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_SETUP, S_READ, S_TEST, S_OUT
    } t_state;

    // queued item between front and back
    typedef struct packed {
        logic        cmd;
        logic [5:0]  vx;
        logic [5:0]  vy;
        logic [5:0]  vz;
        logic        solid;
        logic [15:0] ox;
        logic [15:0] oy;
        logic [15:0] oz;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] dz;
    } t_item;
endpackage

[rtl/core/vgrt_ram.sv]
// generic simple dual port ram (one write port, one read port) with registered read
// no dependencies
module vgrt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

[rtl/core/vgrt_front.sv]
// front: accepts input beats and queues them as items
// depends on vgrt_pkg
module vgrt_front #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  vgrt_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_pop,
    output vgrt_pkg::t_item o_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    vgrt_pkg::t_item r_q [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push = i_valid && o_ready;
    assign pop = i_pop && o_valid;
    assign o_item = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
    end
endmodule

[rtl/core/vgrt_back.sv]
// back: divider, dda walk and occupancy ram
// depends on vgrt_pkg, vgrt_ram
module vgrt_back #(
    parameter int GRID_BITS = vgrt_pkg::GRID_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [15:0]     i_max_dist,
    input  logic            i_valid,
    output logic            o_pop,
    input  vgrt_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [46:0]     o_data,
    output logic            o_busy
);
    localparam int AB = 3*GRID_BITS;
    localparam int DEPTH = 1 << AB;
    localparam logic [6:0] GSIZE = 7'(1 << GRID_BITS);

    vgrt_pkg::t_state r_state, n_state;
    // clearing pass over the occupancy ram
    logic [AB:0] r_clr;
    logic clearing;
    assign clearing = !r_clr[AB];

    vgrt_pkg::t_item r_it;
    logic [1:0]  r_ax;
    logic [4:0]  r_bit;
    logic [22:0] r_rem;
    logic [22:0] r_quo;
    logic [15:0] r_mag;
    logic [15:0] r_delta [3];
    logic [31:0] r_side [3];
    logic signed [9:0] r_cell [3];
    logic [1:0]  r_stepk [3]; // bit1 neg, bit0 move
    logic [31:0] r_dist;
    logic        r_hit;
    logic [15:0] mul_a;
    logic [15:0] mul_b;
    logic [31:0] mul_p;
    logic        rd;

    // ram interface
    logic we;
    logic [AB-1:0] waddr, raddr;
    logic wdata;
    logic inside_g;
    logic [15:0] dsel;
    logic [11:0] fsel;
    logic [22:0] div_sh;
    logic        div_ge;
    logic [22:0] quo_nx;
    logic [1:0] k;

    vgrt_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rd)
    );

    function automatic logic [15:0] absv(input logic [15:0] d);
        absv = d[15] ? (~d + 16'd1) : d;
    endfunction

    always_comb begin
        unique case (r_ax)
            2'd0: begin dsel = r_it.dx; fsel = r_it.ox[11:0]; end
            2'd1: begin dsel = r_it.dy; fsel = r_it.oy[11:0]; end
            default: begin dsel = r_it.dz; fsel = r_it.oz[11:0]; end
        endcase
    end

    assign we = clearing || (r_state == vgrt_pkg::S_IDLE && i_valid
        && i_item.cmd == vgrt_pkg::CMD_WRITE && {1'b0, i_item.vx} < GSIZE
        && {1'b0, i_item.vy} < GSIZE && {1'b0, i_item.vz} < GSIZE);
    assign wdata = clearing ? 1'b0 : i_item.solid;
    assign waddr = clearing ? r_clr[AB-1:0] :
        {i_item.vz[GRID_BITS-1:0], i_item.vy[GRID_BITS-1:0], i_item.vx[GRID_BITS-1:0]};
    assign raddr = {r_cell[2][GRID_BITS-1:0], r_cell[1][GRID_BITS-1:0],
        r_cell[0][GRID_BITS-1:0]};
    assign inside_g = r_cell[0][9:GRID_BITS] == '0 && r_cell[1][9:GRID_BITS] == '0
        && r_cell[2][9:GRID_BITS] == '0;

    assign mul_a = dsel[15] ? {4'd0, fsel} : 16'(13'd4096 - {1'b0, fsel});
    assign mul_b = r_delta[r_ax];
    assign mul_p = mul_a * mul_b;

    // one restoring step: bring down the next dividend bit of 2^22
    assign div_sh = {r_rem[21:0], (r_bit == 5'd22)};
    assign div_ge = div_sh >= {7'd0, r_mag};
    assign quo_nx = {r_quo[21:0], div_ge};

    always_comb begin
        if (r_side[0] <= r_side[1] && r_side[0] <= r_side[2]) k = 2'd0;
        else if (r_side[1] <= r_side[2]) k = 2'd1;
        else k = 2'd2;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vgrt_pkg::S_IDLE: begin
                if (!clearing && i_valid && i_item.cmd == vgrt_pkg::CMD_CAST) begin
                    n_state = vgrt_pkg::S_DIV;
                end
            end
            vgrt_pkg::S_DIV: if (r_bit == 5'd0 && r_ax == 2'd2) n_state = vgrt_pkg::S_SETUP;
            vgrt_pkg::S_SETUP: if (r_ax == 2'd2) n_state = vgrt_pkg::S_READ;
            vgrt_pkg::S_READ: begin
                if (r_dist >= {16'd0, i_max_dist}) n_state = vgrt_pkg::S_OUT;
                else n_state = vgrt_pkg::S_TEST;
            end
            vgrt_pkg::S_TEST: begin
                if (inside_g && rd) n_state = vgrt_pkg::S_OUT;
                else n_state = vgrt_pkg::S_READ;
            end
            vgrt_pkg::S_OUT: if (i_ready) n_state = vgrt_pkg::S_IDLE;
            default: n_state = vgrt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_pop = !clearing && r_state == vgrt_pkg::S_IDLE && i_valid;
        o_valid = r_state == vgrt_pkg::S_OUT;
        o_busy = r_state != vgrt_pkg::S_IDLE;
        o_data = {(r_dist > 32'hFFFF) ? 16'hFFFF : r_dist[15:0],
            r_cell[2], r_cell[1], r_cell[0], r_hit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vgrt_pkg::S_IDLE;
            r_clr <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) r_clr <= r_clr + 1'b1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            vgrt_pkg::S_IDLE: begin
                r_it <= i_item;
                r_ax <= 2'd0;
                r_bit <= 5'd22;
                r_rem <= '0;
                r_quo <= '0;
                r_mag <= absv(i_item.dx);
                r_dist <= '0;
                r_hit <= 1'b0;
            end
            vgrt_pkg::S_DIV: begin
                // restoring divide of 2^22 by |dir|, one quotient bit a cycle
                if (r_mag == 16'd0) begin
                    r_delta[r_ax] <= vgrt_pkg::DELTA_MAX;
                    r_bit <= 5'd0;
                end else begin
                    r_rem <= div_ge ? div_sh - {7'd0, r_mag} : div_sh;
                    r_quo <= quo_nx;
                    if (r_bit != 5'd0) r_bit <= r_bit - 5'd1;
                end
                if (r_bit == 5'd0) begin
                    if (r_mag != 16'd0) begin
                        r_delta[r_ax] <= (quo_nx[22:16] != '0) ? vgrt_pkg::DELTA_MAX
                            : quo_nx[15:0];
                    end
                    r_bit <= 5'd22;
                    r_rem <= '0;
                    r_quo <= '0;
                    r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                    r_mag <= absv(r_ax == 2'd0 ? r_it.dy : r_it.dz);
                end
            end
            vgrt_pkg::S_SETUP: begin
                r_side[r_ax] <= {12'd0, mul_p[31:12]};
                r_cell[r_ax] <= {6'd0, (r_ax == 2'd0) ? r_it.ox[15:12] :
                    (r_ax == 2'd1) ? r_it.oy[15:12] : r_it.oz[15:12]};
                r_stepk[r_ax] <= {dsel[15], dsel != 16'd0};
                r_ax <= r_ax + 2'd1;
            end
            vgrt_pkg::S_TEST: begin
                if (inside_g && rd) begin
                    r_hit <= 1'b1;
                end else begin
                    r_dist <= r_side[k];
                    r_side[k] <= r_side[k] + {16'd0, r_delta[k]};
                    if (r_stepk[k][0]) begin
                        r_cell[k] <= r_stepk[k][1] ? r_cell[k] - 10'sd1 : r_cell[k] + 10'sd1;
                    end
                end
            end
            default: ;
        endcase
    end
endmodule

[rtl/core/voxel_grid_ray_traversal_core.sv]
// channel   | dir | payload
// s_axis    | in  | tuser: command; tdata: voxel_x,voxel_y,voxel_z,solid,origin xyz,dir xyz
// m_axis    | out | tdata: hit,hit_x,hit_y,hit_z,distance
// cfg       | in  | max_distance write
// a cast leaves the queue, runs three 23-step reciprocal divides (cut short for a zero
// component) and a side setup per axis, then walks with a ram read then a test per voxel
// until a test finds a solid voxel or a read sees the limit, and waits on m_axis
// a write goes to the ram as it leaves the queue
// after reset a clearing pass over all 2^(3*GRID_BITS) cells zeroes the grid
// a two-entry queue lets input beats land while a result stalls on m_axis
`include "assert_macros.svh"
module voxel_grid_ray_traversal_core #(
    parameter int GRID_BITS = vgrt_pkg::GRID_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command
    input  logic         s_axis_tuser,
    // voxel_x, voxel_y, voxel_z, solid, origin_x/y/z, dir_x/y/z (lsb up)
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit, hit_x, hit_y, hit_z, distance (lsb up)
    output logic [47:0]  m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata
);
    logic [15:0] r_max_dist;
    vgrt_pkg::t_item in_item, q_item;
    logic q_valid, q_pop, busy;
    logic [46:0] bdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max_dist <= vgrt_pkg::MAX_DIST_RST;
        else if (i_cfg_we) r_max_dist <= i_cfg_wdata;
    end

    always_comb begin
        in_item.cmd = s_axis_tuser;
        in_item.vx = {2'd0, s_axis_tdata[3:0]};
        in_item.vy = {2'd0, s_axis_tdata[7:4]};
        in_item.vz = {2'd0, s_axis_tdata[11:8]};
        in_item.solid = s_axis_tdata[12];
        in_item.ox = s_axis_tdata[28:13];
        in_item.oy = s_axis_tdata[44:29];
        in_item.oz = s_axis_tdata[60:45];
        in_item.dx = s_axis_tdata[76:61];
        in_item.dy = s_axis_tdata[92:77];
        in_item.dz = s_axis_tdata[108:93];
    end

    vgrt_front #(.DEPTH(2)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_item(in_item), .o_valid(q_valid), .i_pop(q_pop), .o_item(q_item)
    );

    vgrt_back #(.GRID_BITS(GRID_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_max_dist(r_max_dist), .i_valid(q_valid),
        .o_pop(q_pop), .i_item(q_item), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_data(bdata), .o_busy(busy)
    );
    assign m_axis_tdata = {1'b0, bdata};

    `ASSERT_IMPL(a_pop_idle, i_clk, i_rst_n, q_pop, !busy && q_valid)
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ASSERT_IMPL(a_out_busy, i_clk, i_rst_n, m_axis_tvalid, busy)
endmodule

[tb/sv/tb_voxel_grid_ray_traversal_core.sv]
// self-checking testbench for voxel_grid_ray_traversal_core: voxel writes update a model grid
// and ray casts are checked against typed results or a behavioral ray walker kept in this file
// depends on vgrt_pkg and the core rtl
`timescale 1ns / 1ps
module tb_voxel_grid_ray_traversal_core;

    localparam int LIMIT_CYCLES = 40000000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic               cmd;
        logic [3:0]         vx;
        logic [3:0]         vy;
        logic [3:0]         vz;
        logic               solid;
        logic [15:0]        ox;
        logic [15:0]        oy;
        logic [15:0]        oz;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
    } ray_cmd_t;

    // msb first: distance, hit_z, hit_y, hit_x, hit
    typedef struct packed {
        logic [15:0] dst;
        logic [9:0]  hz;
        logic [9:0]  hy;
        logic [9:0]  hx;
        logic        hit;
    } ray_res_t;

    typedef struct {
        ray_cmd_t c;
        bit       typed;
        ray_res_t r;
    } stim_row_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // command
    logic         s_axis_tuser = 1'b0;
    // voxel_x, voxel_y, voxel_z, solid, origin_x/y/z, dir_x/y/z (lsb up)
    logic [111:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // hit, hit_x, hit_y, hit_z, distance (lsb up)
    logic [47:0]  m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [15:0]  i_cfg_wdata = '0;

    bit          occ [0:4095];
    int unsigned walk_limit = 16384;
    ray_res_t    hits_due [$];
    int          errors = 0;
    int          cycles = 0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int          rx_wait = 0;

    voxel_grid_ray_traversal_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // 3d dda walk with the block's fixed point rules
    function automatic ray_res_t trace_ray(ray_cmd_t c);
        int                 vox [3];
        int                 stp [3];
        int unsigned        dl [3];
        int unsigned        sd [3];
        logic [15:0]        org [3];
        logic signed [15:0] dr [3];
        int unsigned        mag;
        int unsigned        fr;
        int unsigned        span;
        int                 k;
        ray_res_t           r;
        org = '{c.ox, c.oy, c.oz};
        dr = '{c.dx, c.dy, c.dz};
        span = 0;
        r.hit = 1'b0;
        for (int a = 0; a < 3; a++) begin
            vox[a] = org[a][15:12];
            fr = org[a][11:0];
            mag = (dr[a] < 0) ? -int'(dr[a]) : int'(dr[a]);
            dl[a] = (mag == 0) ? 65535 : (32'd4194304 / mag);
            if (dl[a] > 65535) dl[a] = 65535;
            stp[a] = (dr[a] > 0) ? 1 : ((dr[a] < 0) ? -1 : 0);
            sd[a] = (dr[a] < 0) ? ((fr * dl[a]) >> 12) : (((4096 - fr) * dl[a]) >> 12);
        end
        while (span < walk_limit) begin
            if (vox[0] >= 0 && vox[0] < 16 && vox[1] >= 0 && vox[1] < 16 &&
                vox[2] >= 0 && vox[2] < 16 &&
                occ[vox[2] * 256 + vox[1] * 16 + vox[0]]) begin
                r.hit = 1'b1;
                break;
            end
            // ties favor x, then y
            if (sd[0] <= sd[1] && sd[0] <= sd[2]) k = 0;
            else if (sd[1] <= sd[2]) k = 1;
            else k = 2;
            span = sd[k];
            sd[k] += dl[k];
            vox[k] += stp[k];
        end
        r.hx = 10'(vox[0]);
        r.hy = 10'(vox[1]);
        r.hz = 10'(vox[2]);
        r.dst = (span > 65535) ? 16'hFFFF : span[15:0];
        return r;
    endfunction

    function automatic ray_cmd_t voxel_write(int x, int y, int z, bit s);
        ray_cmd_t c;
        c = '0;
        c.cmd = vgrt_pkg::CMD_WRITE;
        c.vx = 4'(x);
        c.vy = 4'(y);
        c.vz = 4'(z);
        c.solid = s;
        return c;
    endfunction

    function automatic ray_cmd_t ray_cast(int ox, int oy, int oz, int dx, int dy, int dz);
        ray_cmd_t c;
        c = '0;
        c.cmd = vgrt_pkg::CMD_CAST;
        c.ox = 16'(ox);
        c.oy = 16'(oy);
        c.oz = 16'(oz);
        c.dx = 16'(dx);
        c.dy = 16'(dy);
        c.dz = 16'(dz);
        return c;
    endfunction

    function automatic ray_res_t res(bit h, int x, int y, int z, int d);
        ray_res_t r;
        r.hit = h;
        r.hx = 10'(x);
        r.hy = 10'(y);
        r.hz = 10'(z);
        r.dst = 16'(d);
        return r;
    endfunction

    function automatic int rand_dir();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(0, 1) ? $urandom_range(1, 64) : -$urandom_range(1, 64);
            2: return $urandom_range(0, 1) ? 32767 : -32768;
            default: return int'($signed(16'($urandom())));
        endcase
    endfunction

    function automatic ray_cmd_t rand_cmd();
        if ($urandom_range(0, 99) < 35)
            return voxel_write($urandom_range(0, 15), $urandom_range(0, 15),
                               $urandom_range(0, 15), $urandom_range(0, 99) < 70);
        return ray_cast($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), rand_dir(), rand_dir(), rand_dir());
    endfunction

    task automatic send_cmd(ray_cmd_t c, bit typed, ray_res_t r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= c.cmd;
        s_axis_tdata <= {3'b000, c.dz, c.dy, c.dx, c.oz, c.oy, c.ox,
                         c.solid, c.vz, c.vy, c.vx};
        do @(posedge i_clk); while (!s_axis_tready);
        if (c.cmd == vgrt_pkg::CMD_WRITE)
            occ[{c.vz, c.vy, c.vx}] = c.solid;
        else
            hits_due.push_back(typed ? r : trace_ray(c));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (hits_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_limit(int unsigned v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= 16'(v);
        walk_limit = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random(int n);
        for (int i = 0; i < n; i++) send_cmd(rand_cmd(), 1'b0, '0);
    endtask

    // result side: random stalls per beat, one long hold when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_req && !hold_done) begin
                rx_wait = 400;
                hold_done = 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                rx_wait = calm ? 0 : $urandom_range(0, 5);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_axis_tready <= (rx_wait == 0);
        end
    end

    always @(posedge i_clk) begin
        ray_res_t got;
        ray_res_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[46:0];
            if (hits_due.size() == 0) begin
                $error("result beat with nothing pending: %h", got);
                errors++;
            end else begin
                want = hits_due.pop_front();
                if (got.hit !== want.hit) begin
                    $error("hit: expected %0d got %0d", want.hit, got.hit);
                    errors++;
                end
                if (got.hx !== want.hx) begin
                    $error("hit_x: expected %0d got %0d", $signed(want.hx), $signed(got.hx));
                    errors++;
                end
                if (got.hy !== want.hy) begin
                    $error("hit_y: expected %0d got %0d", $signed(want.hy), $signed(got.hy));
                    errors++;
                end
                if (got.hz !== want.hz) begin
                    $error("hit_z: expected %0d got %0d", $signed(want.hz), $signed(got.hz));
                    errors++;
                end
                if (got.dst !== want.dst) begin
                    $error("distance: expected %0d got %0d", want.dst, got.dst);
                    errors++;
                end
            end
        end
    end

    initial begin
        stim_row_t   rows [$];
        int unsigned limits [6];
        for (int i = 0; i < 4096; i++) occ[i] = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, default limit of 64.0
        rows.push_back('{ray_cast(0, 0, 0, 16384, 0, 0), 1, res(0, 64, 0, 0, 16384)});
        rows.push_back('{voxel_write(0, 0, 0, 1), 0, '0});
        rows.push_back('{ray_cast(0, 0, 0, 0, 0, 0), 1, res(1, 0, 0, 0, 0)});
        rows.push_back('{voxel_write(15, 15, 15, 1), 0, '0});
        rows.push_back('{ray_cast(65535, 65535, 65535, -32768, -32768, -32768), 1,
                         res(1, 15, 15, 15, 0)});
        rows.push_back('{voxel_write(0, 0, 0, 0), 0, '0});
        // zero direction: every axis saturates, x wins the tie, no movement
        rows.push_back('{ray_cast(0, 0, 0, 0, 0, 0), 1, res(0, 0, 0, 0, 65535)});
        rows.push_back('{ray_cast(0, 0, 0, 32767, 32767, 32767), 0, '0});
        rows.push_back('{ray_cast(16'h8000, 16'h8000, 16'h8000, 1, -1, 1), 0, '0});
        rows.push_back('{ray_cast(16'h8000, 16'h8000, 16'h8000, -32768, 0, 0), 0, '0});
        rows.push_back('{voxel_write(5, 8, 8, 1), 0, '0});
        rows.push_back('{ray_cast(16'h8800, 16'h8800, 16'h8800, -16384, 0, 0), 0, '0});
        rows.push_back('{ray_cast(16'h0800, 16'h0800, 16'hF800, 0, 0, 32767), 0, '0});
        rows.push_back('{voxel_write(3, 3, 3, 1), 0, '0});
        rows.push_back('{ray_cast(16'h0800, 16'h0800, 16'h0800, 16384, 16384, 16384), 0, '0});
        rows.push_back('{ray_cast(16'h0FFF, 16'h1000, 16'h2FFF, -1, 32767, -32768), 0, '0});
        foreach (rows[i]) send_cmd(rows[i].c, rows[i].typed, rows[i].r);

        // zero limit: start voxel not tested even when solid
        set_limit(0);
        send_cmd(ray_cast(65535, 65535, 65535, 100, 200, 300), 1'b1, res(0, 15, 15, 15, 0));
        send_random(4);

        // longest limit, coordinates wrap past 511
        set_limit(65535);
        send_cmd(ray_cast(16'hF000, 0, 0, 32767, 0, 0), 1'b0, '0);
        send_cmd(ray_cast(16'h0800, 16'h4000, 16'h4000, -32768, 0, 0), 1'b0, '0);
        send_random(3);

        set_limit(1);
        send_random(8);

        limits = '{16384, 2048, 32768, 512, 8192, 4096};
        foreach (limits[p]) begin
            set_limit(limits[p]);
            calm = (p == 2);
            if (p == 1) hold_req <= 1'b1;
            send_random(280);
        end
        calm = 1'b0;
        set_limit($urandom_range(256, 6000));
        send_random(60);

        drain();
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/vgrt_pkg.sv
rtl/core/vgrt_ram.sv
rtl/core/vgrt_front.sv
rtl/core/vgrt_back.sv
rtl/core/voxel_grid_ray_traversal_core.sv
tb/sv/tb_voxel_grid_ray_traversal_core.sv
